// ----- rtl/bptl_pkg.sv -----
// Shared types and constants for the bilinear property table lookup.
// Used by the top level and the weight divider; no dependencies.
package bptl_pkg;

    localparam int VALUE_W        = 32;
    localparam int FRAC_W         = 16;
    localparam int W_W            = 17;
    localparam logic [W_W-1:0] W_ONE = 17'h10000;
    localparam int NUM_PROPERTIES = 11;
    localparam int MIX_POINTS_W   = 7;
    localparam int VAR_POINTS_W   = 6;
    localparam int CFG_DATA_W     = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int CMD_W          = 2;
    localparam int SLICE_IN_W     = 4;
    localparam int PROP_W         = 4;
    localparam int ADDR_IN_W      = 15;

    // Weight divider: signed numerator and denominator, unsigned magnitudes.
    localparam int NUM_W       = 34;
    localparam int MAG_W       = 33;
    localparam int DIV_STAGES  = 8;
    localparam int DIV_BITS    = 2;
    localparam int DIV_LATENCY = DIV_STAGES + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_MIX,
        CMD_LOAD_VAR,
        CMD_LOAD_TABLE,
        CMD_LOOKUP
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIX_POINTS,
        REG_VAR_POINTS
    } t_reg_idx;

    typedef struct packed {
        t_cmd                        command;
        logic [FRAC_W-1:0]           mix_fraction;
        logic [FRAC_W-1:0]           variance;
        logic [SLICE_IN_W-1:0]       axial_slice;
        logic [PROP_W-1:0]           load_property;
        logic [ADDR_IN_W-1:0]        load_address;
        logic signed [VALUE_W-1:0]   load_value;
    } t_item;

endpackage

// ----- rtl/bptl_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module bptl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ----- rtl/bptl_wdiv.sv -----
// Pipelined interpolation weight unit: (hi - x) / (hi - lo) as Q1.16, clamped to [0, 1].
// Depends on bptl_pkg.
module bptl_wdiv (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [bptl_pkg::NUM_W-1:0] i_num,
    input  logic signed [bptl_pkg::NUM_W-1:0] i_den,
    output logic [bptl_pkg::W_W-1:0]          o_weight
);
    import bptl_pkg::*;

    typedef struct packed {
        logic             preset;
        logic [W_W-1:0]   pval;
        logic [MAG_W-1:0] den;
        logic [MAG_W-1:0] rem;
        logic [FRAC_W-1:0] quot;
    } t_dstage;

    t_dstage r_st [0:DIV_STAGES];
    t_dstage n_first;
    t_dstage n_st [1:DIV_STAGES];

    logic             num_pos;
    logic             den_pos;
    logic [MAG_W-1:0] an;
    logic [MAG_W-1:0] ad;

    // First stage sorts out the degenerate and clamped cases.
    always_comb begin
        num_pos = !i_num[NUM_W-1] && (i_num != '0);
        den_pos = !i_den[NUM_W-1] && (i_den != '0);
        an = i_num[NUM_W-1] ? MAG_W'(-i_num) : MAG_W'(i_num);
        ad = i_den[NUM_W-1] ? MAG_W'(-i_den) : MAG_W'(i_den);
        n_first.preset = 1'b1;
        n_first.pval   = '0;
        n_first.den    = ad;
        n_first.rem    = an;
        n_first.quot   = '0;
        if (i_den == '0) begin
            n_first.pval = num_pos ? W_ONE : '0;
        end else if (i_num == '0 || num_pos != den_pos) begin
            n_first.pval = '0;
        end else if (an >= ad) begin
            n_first.pval = W_ONE;
        end else begin
            n_first.preset = 1'b0;
        end
    end

    // Restoring division, DIV_BITS quotient bits per stage.
    always_comb begin
        t_dstage        s;
        logic [MAG_W:0] t;
        for (int k = 1; k <= DIV_STAGES; k++) begin
            s = r_st[k-1];
            for (int j = 0; j < DIV_BITS; j++) begin
                t = {s.rem, 1'b0};
                if (t >= {1'b0, s.den}) begin
                    s.rem  = MAG_W'(t - {1'b0, s.den});
                    s.quot = {s.quot[FRAC_W-2:0], 1'b1};
                end else begin
                    s.rem  = MAG_W'(t);
                    s.quot = {s.quot[FRAC_W-2:0], 1'b0};
                end
            end
            n_st[k] = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_first;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_weight = r_st[DIV_STAGES].preset ? r_st[DIV_STAGES].pval
                                              : {1'b0, r_st[DIV_STAGES].quot};

endmodule

// ----- rtl/bilinear_property_table_lookup.sv -----
// Bilinear lookup of eleven property tables over a uniform mixture-fraction axis
// and a nonuniform variance axis. Depends on bptl_pkg, bptl_ram and bptl_wdiv.
//
//  channel   direction  handshake                  payload
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//  command   in         i_in_valid / o_in_ready    i_command .. i_load_value
//  result    out        o_out_valid / i_out_ready  o_density .. o_soot_radiation
//
// One item enters per cycle while the output is not stalled. A lookup passes through
// the nine-stage weight divider and the registered table reads before its result appears.
// Loads flow through the same pipeline and write each store at the stage that reads it.
// Any stall at the output freezes the whole pipeline. Reset clears only control state
// and the point-count registers; the axis and table stores need no clearing pass.
module bilinear_property_table_lookup #(
    parameter int MAX_MIX_POINTS   = 64,
    parameter int MAX_VAR_POINTS   = 32,
    parameter int MAX_AXIAL_SLICES = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [bptl_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [bptl_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [bptl_pkg::CMD_W-1:0]              i_command,
    input  logic [bptl_pkg::FRAC_W-1:0]             i_mix_fraction,
    input  logic [bptl_pkg::FRAC_W-1:0]             i_variance,
    input  logic [bptl_pkg::SLICE_IN_W-1:0]         i_axial_slice,
    input  logic [bptl_pkg::PROP_W-1:0]             i_load_property,
    input  logic [bptl_pkg::ADDR_IN_W-1:0]          i_load_address,
    input  logic signed [bptl_pkg::VALUE_W-1:0]     i_load_value,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [bptl_pkg::VALUE_W-1:0]     o_density,
    output logic signed [bptl_pkg::VALUE_W-1:0]     o_temperature,
    output logic signed [bptl_pkg::VALUE_W-1:0]     o_soot_fraction,
    output logic signed [bptl_pkg::VALUE_W-1:0]     o_carbon_dioxide,
    output logic signed [bptl_pkg::VALUE_W-1:0]     o_water_vapour,
    output logic signed [bptl_pkg::VALUE_W-1:0]     o_soot_temp_five,
    output logic signed [bptl_pkg::VALUE_W-1:0]     o_temp_fourth,
    output logic signed [bptl_pkg::VALUE_W-1:0]     o_temp_fifth,
    output logic signed [bptl_pkg::VALUE_W-1:0]     o_temp_ninth,
    output logic signed [bptl_pkg::VALUE_W-1:0]     o_gas_radiation,
    output logic signed [bptl_pkg::VALUE_W-1:0]     o_soot_radiation
);
    import bptl_pkg::*;

    localparam int AW_M  = $clog2(MAX_MIX_POINTS);
    localparam int AW_V  = $clog2(MAX_VAR_POINTS);
    localparam int SPAN  = MAX_MIX_POINTS * MAX_VAR_POINTS * MAX_AXIAL_SLICES;
    localparam int AW_T  = $clog2(SPAN);
    localparam int NM_W  = $clog2(MAX_MIX_POINTS + 1);
    localparam int NV_W  = $clog2(MAX_VAR_POINTS + 1);
    localparam int SL_W  = $clog2(MAX_AXIAL_SLICES + 1);
    localparam int SN_W  = $clog2(MAX_AXIAL_SLICES * MAX_VAR_POINTS + 1);
    localparam int S_DIV = 3;
    localparam int S_TAB = S_DIV + DIV_LATENCY - 1;
    localparam int S_W   = S_TAB + 1;
    localparam int S_OUT = S_W + 4;

    typedef struct packed {
        logic                      look;
        logic                      ltab;
        logic [PROP_W-1:0]         prop;
        logic [AW_T-1:0]           waddr;
        logic signed [VALUE_W-1:0] wval;
        logic [AW_T-1:0]           a00;
        logic [AW_T-1:0]           a01;
        logic [AW_T-1:0]           a10;
        logic [AW_T-1:0]           a11;
    } t_mid;

    // Configuration and control.
    logic [MIX_POINTS_W-1:0] r_mix_points;
    logic [VAR_POINTS_W-1:0] r_var_points;
    logic [S_OUT:0]          r_v;
    logic                    adv;
    logic [NM_W-1:0]         nm;
    logic [NV_W-1:0]         nv;

    // Stage payloads.
    t_item                     r0_item, r1_item, r2_item;
    logic [AW_M-1:0]           r1_xlo, r2_xlo;
    logic [SL_W-1:0]           r1_slice;
    logic [MAX_VAR_POINTS-1:0] r1_lt;
    logic [AW_V-1:0]           r2_ylo;
    logic [SN_W-1:0]           r2_sn;
    logic signed [VALUE_W-1:0] r_vaxis [MAX_VAR_POINTS];
    t_item                     r3_item;
    logic signed [NUM_W-1:0]   r3_numx, r3_denx, r3_numy, r3_deny;
    logic [AW_T-1:0]           r3_xlo, r3_ylnm, r3_base;
    t_mid                      r_mid [S_DIV+1:S_TAB];

    logic signed [49:0]        r13_p   [NUM_PROPERTIES][4];
    logic [W_W-1:0]            r13_wy, r14_wy;
    logic signed [32:0]        r14_row [NUM_PROPERTIES][2];
    logic signed [50:0]        r15_q   [NUM_PROPERTIES][2];
    logic signed [VALUE_W-1:0] r_out   [NUM_PROPERTIES];

    // Combinational signals.
    logic [FRAC_W+NM_W-1:0]    mix_prod;
    logic [NM_W-1:0]           xraw;
    logic [AW_M-1:0]           xlo_c;
    logic [SL_W-1:0]           slice_c;
    logic [MAX_VAR_POINTS-1:0] lt_c;
    logic                      found;
    logic [AW_V-1:0]           hit;
    logic [AW_V-1:0]           ylo_c;
    logic [SN_W-1:0]           sn_c;
    logic [VALUE_W-1:0]        mix_lo_q, mix_hi_q, var_lo_q, var_hi_q;
    logic signed [NUM_W-1:0]   mix_hi_x, mix_lo_x, var_hi_x, var_lo_x;
    logic [W_W-1:0]            wx, wy, wxh;
    logic signed [VALUE_W-1:0] tab_q [NUM_PROPERTIES][4];
    logic [NUM_PROPERTIES-1:0] tab_we;
    t_mid                      mid_c;

    assign adv        = !r_v[S_OUT] || i_out_ready;
    assign o_in_ready = adv;
    assign o_out_valid = r_v[S_OUT];

    always_comb begin
        if (int'(r_mix_points) < 2) begin
            nm = NM_W'(2);
        end else if (int'(r_mix_points) > MAX_MIX_POINTS) begin
            nm = NM_W'(MAX_MIX_POINTS);
        end else begin
            nm = NM_W'(r_mix_points);
        end
        if (int'(r_var_points) < 2) begin
            nv = NV_W'(2);
        end else if (int'(r_var_points) > MAX_VAR_POINTS) begin
            nv = NV_W'(MAX_VAR_POINTS);
        end else begin
            nv = NV_W'(r_var_points);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_points <= MIX_POINTS_W'(64);
            r_var_points <= VAR_POINTS_W'(32);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MIX_POINTS: r_mix_points <= i_cfg_data[MIX_POINTS_W-1:0];
                REG_VAR_POINTS: r_var_points <= i_cfg_data[VAR_POINTS_W-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits. Results drop out at the table stage unless the item is a lookup.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v[0] <= i_in_valid;
            for (int k = 1; k <= S_TAB; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_v[S_W] <= r_v[S_TAB] && r_mid[S_TAB].look;
            for (int k = S_W + 1; k <= S_OUT; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // Stage 0 to 1: mixture cell, slice clamp and the variance axis compare.
    always_comb begin
        mix_prod = (FRAC_W+NM_W)'(r0_item.mix_fraction) * (FRAC_W+NM_W)'(nm - NM_W'(1));
        xraw     = mix_prod[FRAC_W+NM_W-1:FRAC_W];
        xlo_c    = (xraw > nm - NM_W'(2)) ? AW_M'(nm - NM_W'(2)) : AW_M'(xraw);
        slice_c  = (int'(r0_item.axial_slice) > MAX_AXIAL_SLICES - 1)
                   ? SL_W'(MAX_AXIAL_SLICES - 1) : SL_W'(r0_item.axial_slice);
        for (int i = 0; i < MAX_VAR_POINTS; i++) begin
            lt_c[i] = (i < int'(nv) - 1) &&
                      ($signed({16'b0, r0_item.variance}) < r_vaxis[i]);
        end
    end

    // The variance axis is kept in flip-flops for the parallel compare; a RAM copy
    // serves the two reads at the chosen cell.
    always_ff @(posedge i_clk) begin
        if (adv && r_v[0] && r0_item.command == CMD_LOAD_VAR &&
            int'(r0_item.load_address) < MAX_VAR_POINTS) begin
            r_vaxis[AW_V'(r0_item.load_address)] <= r0_item.load_value;
        end
    end

    // Stage 1: first axis point above the input picks the variance cell.
    always_comb begin
        found = 1'b0;
        hit   = '0;
        for (int i = MAX_VAR_POINTS - 1; i >= 0; i--) begin
            if (r1_lt[i]) begin
                found = 1'b1;
                hit   = AW_V'(i);
            end
        end
        if (!found) begin
            ylo_c = AW_V'(nv - NV_W'(2));
        end else if (hit == '0) begin
            ylo_c = '0;
        end else begin
            ylo_c = hit - AW_V'(1);
        end
        sn_c = SN_W'(SN_W'(r1_slice) * SN_W'(nv));
    end

    bptl_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_MIX_POINTS)) u_mix_ram (
        .i_clk     (i_clk),
        .i_we      (adv && r_v[1] && r1_item.command == CMD_LOAD_MIX &&
                    int'(r1_item.load_address) < MAX_MIX_POINTS),
        .i_waddr   (AW_M'(r1_item.load_address)),
        .i_wdata   (r1_item.load_value),
        .i_re      (adv),
        .i_raddr_a (r1_xlo),
        .i_raddr_b (r1_xlo + AW_M'(1)),
        .o_rdata_a (mix_lo_q),
        .o_rdata_b (mix_hi_q)
    );

    bptl_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_VAR_POINTS)) u_var_ram (
        .i_clk     (i_clk),
        .i_we      (adv && r_v[1] && r1_item.command == CMD_LOAD_VAR &&
                    int'(r1_item.load_address) < MAX_VAR_POINTS),
        .i_waddr   (AW_V'(r1_item.load_address)),
        .i_wdata   (r1_item.load_value),
        .i_re      (adv),
        .i_raddr_a (ylo_c),
        .i_raddr_b (ylo_c + AW_V'(1)),
        .o_rdata_a (var_lo_q),
        .o_rdata_b (var_hi_q)
    );

    // Stage 2 to 3: weight numerators and denominators, address partial products.
    always_comb begin
        mix_hi_x = $signed({{(NUM_W-VALUE_W){mix_hi_q[VALUE_W-1]}}, mix_hi_q});
        mix_lo_x = $signed({{(NUM_W-VALUE_W){mix_lo_q[VALUE_W-1]}}, mix_lo_q});
        var_hi_x = $signed({{(NUM_W-VALUE_W){var_hi_q[VALUE_W-1]}}, var_hi_q});
        var_lo_x = $signed({{(NUM_W-VALUE_W){var_lo_q[VALUE_W-1]}}, var_lo_q});
    end

    // Stage 3 to the table stage: corner addresses.
    always_comb begin
        mid_c.look  = r3_item.command == CMD_LOOKUP;
        mid_c.ltab  = r3_item.command == CMD_LOAD_TABLE &&
                      int'(r3_item.load_property) < NUM_PROPERTIES &&
                      int'(r3_item.load_address) < SPAN;
        mid_c.prop  = r3_item.load_property;
        mid_c.waddr = AW_T'(r3_item.load_address);
        mid_c.wval  = r3_item.load_value;
        mid_c.a00   = r3_xlo + r3_ylnm + r3_base;
        mid_c.a01   = mid_c.a00 + AW_T'(1);
        mid_c.a10   = mid_c.a00 + AW_T'(nm);
        mid_c.a11   = mid_c.a10 + AW_T'(1);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_item  <= t_item'({i_command, i_mix_fraction, i_variance, i_axial_slice,
                                 i_load_property, i_load_address, i_load_value});
            r1_item  <= r0_item;
            r1_xlo   <= xlo_c;
            r1_slice <= slice_c;
            r1_lt    <= lt_c;
            r2_item  <= r1_item;
            r2_xlo   <= r1_xlo;
            r2_ylo   <= ylo_c;
            r2_sn    <= sn_c;
            r3_item  <= r2_item;
            r3_numx  <= mix_hi_x - $signed({{(NUM_W-FRAC_W){1'b0}}, r2_item.mix_fraction});
            r3_denx  <= mix_hi_x - mix_lo_x;
            r3_numy  <= var_hi_x - $signed({{(NUM_W-FRAC_W){1'b0}}, r2_item.variance});
            r3_deny  <= var_hi_x - var_lo_x;
            r3_xlo   <= AW_T'(r2_xlo);
            r3_ylnm  <= AW_T'(AW_T'(r2_ylo) * AW_T'(nm));
            r3_base  <= AW_T'(AW_T'(r2_sn) * AW_T'(nm));
            r_mid[S_DIV+1] <= mid_c;
            for (int k = S_DIV + 2; k <= S_TAB; k++) begin
                r_mid[k] <= r_mid[k-1];
            end
        end
    end

    bptl_wdiv u_wdiv_x (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_num    (r3_numx),
        .i_den    (r3_denx),
        .o_weight (wx)
    );

    bptl_wdiv u_wdiv_y (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_num    (r3_numy),
        .i_den    (r3_deny),
        .o_weight (wy)
    );

    // Two copies of each table so that all four corners are read in the same cycle.
    for (genvar p = 0; p < NUM_PROPERTIES; p++) begin : g_prop
        assign tab_we[p] = adv && r_v[S_TAB] && r_mid[S_TAB].ltab &&
                           r_mid[S_TAB].prop == PROP_W'(p);
        for (genvar b = 0; b < 2; b++) begin : g_bank
            bptl_ram #(.WIDTH(VALUE_W), .DEPTH(SPAN)) u_tab_ram (
                .i_clk     (i_clk),
                .i_we      (tab_we[p]),
                .i_waddr   (r_mid[S_TAB].waddr),
                .i_wdata   (r_mid[S_TAB].wval),
                .i_re      (adv),
                .i_raddr_a ((b == 0) ? r_mid[S_TAB].a00 : r_mid[S_TAB].a10),
                .i_raddr_b ((b == 0) ? r_mid[S_TAB].a01 : r_mid[S_TAB].a11),
                .o_rdata_a (tab_q[p][2*b]),
                .o_rdata_b (tab_q[p][2*b+1])
            );
        end
    end

    assign wxh = W_ONE - wx;

    // Interpolation: products, row rounding, column products, final rounding and saturation.
    always_ff @(posedge i_clk) begin
        logic signed [50:0] row_sum;
        logic signed [51:0] col_sum;
        logic signed [35:0] col_sh;
        if (adv) begin
            r13_wy <= wy;
            r14_wy <= r13_wy;
            for (int p = 0; p < NUM_PROPERTIES; p++) begin
                r13_p[p][0] <= $signed({1'b0, wx})  * tab_q[p][0];
                r13_p[p][1] <= $signed({1'b0, wxh}) * tab_q[p][1];
                r13_p[p][2] <= $signed({1'b0, wx})  * tab_q[p][2];
                r13_p[p][3] <= $signed({1'b0, wxh}) * tab_q[p][3];
                for (int r = 0; r < 2; r++) begin
                    row_sum = 51'(r13_p[p][2*r]) + 51'(r13_p[p][2*r+1]) + 51'sd32768;
                    r14_row[p][r] <= row_sum[48:16];
                end
                r15_q[p][0] <= $signed({1'b0, r14_wy}) * r14_row[p][0];
                r15_q[p][1] <= $signed({1'b0, W_ONE - r14_wy}) * r14_row[p][1];
                col_sum = 52'(r15_q[p][0]) + 52'(r15_q[p][1]) + 52'sd32768;
                col_sh  = col_sum[51:16];
                if (col_sh[35:31] == 5'b00000 || col_sh[35:31] == 5'b11111) begin
                    r_out[p] <= col_sh[VALUE_W-1:0];
                end else if (col_sh[35]) begin
                    r_out[p] <= {1'b1, {(VALUE_W-1){1'b0}}};
                end else begin
                    r_out[p] <= {1'b0, {(VALUE_W-1){1'b1}}};
                end
            end
        end
    end

    assign o_density        = r_out[0];
    assign o_temperature    = r_out[1];
    assign o_soot_fraction  = r_out[2];
    assign o_carbon_dioxide = r_out[3];
    assign o_water_vapour   = r_out[4];
    assign o_soot_temp_five = r_out[5];
    assign o_temp_fourth    = r_out[6];
    assign o_temp_fifth     = r_out[7];
    assign o_temp_ninth     = r_out[8];
    assign o_gas_radiation  = r_out[9];
    assign o_soot_radiation = r_out[10];

`ifndef SYNTHESIS
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> r_v == $past(r_v))
        else $error("pipeline valid bits moved during an output stall");

    a_mix_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] && r1_item.command == CMD_LOOKUP |-> int'(r1_xlo) <= int'(nm) - 2)
        else $error("mixture cell beyond the last interval");

    a_var_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] && r2_item.command == CMD_LOOKUP |-> int'(r2_ylo) <= int'(nv) - 2)
        else $error("variance cell beyond the last interval");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[S_W] |-> wx <= W_ONE && wy <= W_ONE)
        else $error("interpolation weight above one");
`endif

endmodule
